/* sv/mbf_pkg.sv */
// Shared widths, codes and defaults of the measure boundary finder.
`default_nettype none
package mbf_pkg;

  localparam int OPCODE_W    = 1;
  localparam int ENTRY_IDX_W = 4;
  localparam int TICK_W      = 63;
  localparam int QTICK_W     = 64;
  localparam int NUM_W       = 8;
  localparam int DEN_W       = 8;
  localparam int CFG_W       = 5;

  localparam int MAX_CHANGES_DEF        = 16;
  localparam int TICKS_PER_QUARTER_DEF  = 480;
  localparam int QUARTERS_PER_WHOLE     = 4;
  localparam int NUM_MAX                = (2 ** NUM_W) - 1;

  localparam logic [OPCODE_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_QUERY = 1'b1;

endpackage
`default_nettype wire

/* sv/mbf_if.sv */
// Valid/ready channel interfaces for the input items and the result words.
`default_nettype none
interface mbf_in_if;
  logic                               valid;
  logic                               ready;
  logic [mbf_pkg::OPCODE_W-1:0]       opcode;
  logic [mbf_pkg::ENTRY_IDX_W-1:0]    entry_index;
  logic [mbf_pkg::TICK_W-1:0]         entry_tick;
  logic [mbf_pkg::NUM_W-1:0]          entry_numerator;
  logic [mbf_pkg::DEN_W-1:0]          entry_denominator;
  logic signed [mbf_pkg::QTICK_W-1:0] query_tick;

  modport source (output valid, opcode, entry_index, entry_tick, entry_numerator,
                  entry_denominator, query_tick, input ready);
  modport sink   (input valid, opcode, entry_index, entry_tick, entry_numerator,
                  entry_denominator, query_tick, output ready);
endinterface

interface mbf_out_if;
  logic                         valid;
  logic                         ready;
  logic                         found;
  logic [mbf_pkg::TICK_W-1:0]   before_tick;
  logic [mbf_pkg::TICK_W-1:0]   after_tick;
  logic                         after_valid;

  modport source (output valid, found, before_tick, after_tick, after_valid, input ready);
  modport sink   (input valid, found, before_tick, after_tick, after_valid, output ready);
endinterface
`default_nettype wire

/* sv/measure_boundary_finder.sv */
// Measure boundary finder: time-signature table, linear scan and shared serial divider.
//
//   channel  dir  handshake            payload
//   in_ch    in   valid/ready          opcode, entry fields, query_tick
//   out_ch   out  valid/ready          found, before_tick, after_tick, after_valid
//   cfg      in   cfg_we (no stall)    cfg_wdata = event_count
//
// A query scans the entries in order, then runs the restoring divider, one quotient bit
// per cycle, first for the measure length and then for the offset within the bar.
// One item is in work at a time; the next word may enter while a result waits.
// Reset is synchronous and clears the control state and event_count; the table
// holds whatever was written. A stalled out_ch holds the result register.
`default_nettype none
module measure_boundary_finder #(
  parameter int MAX_CHANGES       = mbf_pkg::MAX_CHANGES_DEF,
  parameter int TICKS_PER_QUARTER = mbf_pkg::TICKS_PER_QUARTER_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  mbf_in_if.sink                         in_ch,
  mbf_out_if.source                      out_ch,
  input  wire logic                      cfg_we,
  input  wire logic [mbf_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W   = (MAX_CHANGES > 1) ? $clog2(MAX_CHANGES) : 1;
  localparam int CNT_W   = $clog2(MAX_CHANGES + 1);
  localparam int BAR_MUL = TICKS_PER_QUARTER * mbf_pkg::QUARTERS_PER_WHOLE;
  localparam int MEAS_W  = $clog2(mbf_pkg::NUM_MAX * BAR_MUL + 1);
  localparam int TW      = mbf_pkg::TICK_W;
  localparam int QW      = mbf_pkg::QTICK_W;
  localparam int STEP_W  = $clog2(QW + 1);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b0000000001,
    ST_READ  = 10'b0000000010,
    ST_CMP   = 10'b0000000100,
    ST_MLOAD = 10'b0000001000,
    ST_MDIV  = 10'b0000010000,
    ST_MCHK  = 10'b0000100000,
    ST_DDIV  = 10'b0001000000,
    ST_NAT   = 10'b0010000000,
    ST_FIN   = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_t;

  // Table storage.
  logic [TW-1:0]                 tick_mem [MAX_CHANGES];
  logic [mbf_pkg::NUM_W-1:0]     num_mem  [MAX_CHANGES];
  logic [mbf_pkg::DEN_W-1:0]     den_mem  [MAX_CHANGES];
  logic [TW-1:0]                 rd_tick_r;
  logic [mbf_pkg::NUM_W-1:0]     rd_num_r;
  logic [mbf_pkg::DEN_W-1:0]     rd_den_r;
  logic [IDX_W-1:0]              rd_addr;
  logic                          mem_we;

  state_t                        state_r, state_nxt;
  logic [mbf_pkg::CFG_W-1:0]     cfg_count_r;
  logic [CNT_W-1:0]              cnt_lim;
  logic [CNT_W-1:0]              idx_r, idx_nxt, idx_inc;
  logic [QW-1:0]                 q_r, q_nxt;
  logic [TW-1:0]                 prev_tick_r, prev_tick_nxt;
  logic [mbf_pkg::NUM_W-1:0]     prev_num_r, prev_num_nxt;
  logic [mbf_pkg::DEN_W-1:0]     prev_den_r, prev_den_nxt;
  logic [TW-1:0]                 next_tick_r, next_tick_nxt;
  logic                          has_next_r, has_next_nxt;

  // Shared restoring divider.
  logic [MEAS_W-1:0]             rem_r, rem_nxt;
  logic [QW-1:0]                 dvd_r, dvd_nxt;
  logic [MEAS_W-1:0]             dsr_r, dsr_nxt;
  logic [STEP_W-1:0]             step_r, step_nxt;
  logic [MEAS_W:0]               trial;
  logic                          trial_ge;
  logic [MEAS_W-1:0]             rem_step;
  logic [MEAS_W-1:0]             bar_len;
  logic [QW-1:0]                 span;

  // Shared magnitude comparator.
  logic [QW-1:0]                 cmp_a, cmp_b;
  logic                          cmp_lt;

  logic [TW-1:0]                 lower_r, lower_nxt;
  logic [QW-1:0]                 nat_r, nat_nxt;
  logic                          res_found_r, res_found_nxt;
  logic [TW-1:0]                 res_before_r, res_before_nxt;
  logic [TW-1:0]                 res_after_r, res_after_nxt;
  logic                          res_avalid_r, res_avalid_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r;
  logic [TW-1:0]                 out_before_r;
  logic [TW-1:0]                 out_after_r;
  logic                          out_avalid_r;
  logic                          out_load;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.found       = out_found_r;
  assign out_ch.before_tick = out_before_r;
  assign out_ch.after_tick  = out_after_r;
  assign out_ch.after_valid = out_avalid_r;

  assign cnt_lim = (32'(cfg_count_r) > 32'(MAX_CHANGES)) ? CNT_W'(MAX_CHANGES)
                                                          : CNT_W'(cfg_count_r);
  assign idx_inc = idx_r + CNT_W'(1);
  assign rd_addr = idx_r[IDX_W-1:0];
  assign mem_we  = in_ch.valid && in_ch.ready && (in_ch.opcode == mbf_pkg::OP_WRITE) &&
                   (32'(in_ch.entry_index) < 32'(MAX_CHANGES));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tick_mem[IDX_W'(in_ch.entry_index)] <= in_ch.entry_tick;
      num_mem[IDX_W'(in_ch.entry_index)]  <= in_ch.entry_numerator;
      den_mem[IDX_W'(in_ch.entry_index)]  <= in_ch.entry_denominator;
    end
    rd_tick_r <= tick_mem[rd_addr];
    rd_num_r  <= num_mem[rd_addr];
    rd_den_r  <= den_mem[rd_addr];
  end

  // One quotient bit per cycle; the quotient shifts into the low end of the dividend.
  assign trial    = {rem_r, dvd_r[QW-1]};
  assign trial_ge = (trial >= {1'b0, dsr_r});
  assign rem_step = trial_ge ? MEAS_W'(trial - {1'b0, dsr_r}) : trial[MEAS_W-1:0];
  assign bar_len  = MEAS_W'(32'(prev_num_r) * 32'(BAR_MUL));
  assign span     = q_r - {1'b0, prev_tick_r};

  always_comb begin
    cmp_a = q_r;
    cmp_b = {1'b0, rd_tick_r};
    if (state_r == ST_FIN) begin
      cmp_a = {1'b0, next_tick_r};
      cmp_b = nat_r;
    end
  end
  assign cmp_lt = (cmp_a < cmp_b);

  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    q_nxt          = q_r;
    prev_tick_nxt  = prev_tick_r;
    prev_num_nxt   = prev_num_r;
    prev_den_nxt   = prev_den_r;
    next_tick_nxt  = next_tick_r;
    has_next_nxt   = has_next_r;
    rem_nxt        = rem_r;
    dvd_nxt        = dvd_r;
    dsr_nxt        = dsr_r;
    step_nxt       = step_r;
    lower_nxt      = lower_r;
    nat_nxt        = nat_r;
    res_found_nxt  = res_found_r;
    res_before_nxt = res_before_r;
    res_after_nxt  = res_after_r;
    res_avalid_nxt = res_avalid_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          q_nxt          = in_ch.query_tick;
          res_found_nxt  = 1'b0;
          res_before_nxt = '0;
          res_after_nxt  = '0;
          res_avalid_nxt = 1'b0;
          idx_nxt        = '0;
          if (in_ch.opcode == mbf_pkg::OP_WRITE || in_ch.query_tick[QW-1] ||
              cnt_lim == '0) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (cmp_lt) begin
          // First entry past the tick: the one before it is the current change.
          next_tick_nxt = rd_tick_r;
          has_next_nxt  = 1'b1;
          state_nxt     = (idx_r == '0) ? ST_DONE : ST_MLOAD;
        end else begin
          prev_tick_nxt = rd_tick_r;
          prev_num_nxt  = rd_num_r;
          prev_den_nxt  = rd_den_r;
          idx_nxt       = idx_inc;
          if (idx_inc == cnt_lim) begin
            has_next_nxt = 1'b0;
            state_nxt    = ST_MLOAD;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_MLOAD: begin
        if (prev_den_r == '0) begin
          state_nxt = ST_DONE;
        end else begin
          rem_nxt   = '0;
          dvd_nxt   = {bar_len, (QW - MEAS_W)'(0)};
          dsr_nxt   = MEAS_W'(prev_den_r);
          step_nxt  = STEP_W'(MEAS_W);
          state_nxt = ST_MDIV;
        end
      end
      ST_MDIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[QW-2:0], trial_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = ST_MCHK;
        end
      end
      ST_MCHK: begin
        // The low bits now hold the measure length, which becomes the divisor.
        if (dvd_r[MEAS_W-1:0] == '0) begin
          state_nxt = ST_DONE;
        end else begin
          dsr_nxt   = dvd_r[MEAS_W-1:0];
          rem_nxt   = '0;
          dvd_nxt   = {span[QW-2:0], 1'b0};
          step_nxt  = STEP_W'(QW - 1);
          state_nxt = ST_DDIV;
        end
      end
      ST_DDIV: begin
        rem_nxt  = rem_step;
        dvd_nxt  = {dvd_r[QW-2:0], trial_ge};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          state_nxt = ST_NAT;
        end
      end
      ST_NAT: begin
        lower_nxt = q_r[TW-1:0] - TW'(rem_r);
        nat_nxt   = {1'b0, q_r[TW-1:0] - TW'(rem_r)} + QW'(dsr_r);
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        res_found_nxt  = 1'b1;
        res_before_nxt = lower_r;
        res_avalid_nxt = 1'b1;
        if (rem_r == '0) begin
          res_after_nxt = lower_r;
        end else if (has_next_r && (nat_r[QW-1] || cmp_lt)) begin
          res_after_nxt = next_tick_r;
        end else if (!nat_r[QW-1]) begin
          res_after_nxt = nat_r[TW-1:0];
        end else begin
          // Bar end does not fit in 63 bits and no later change caps it.
          res_after_nxt  = '0;
          res_avalid_nxt = 1'b0;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cfg_count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        cfg_count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    q_r          <= q_nxt;
    prev_tick_r  <= prev_tick_nxt;
    prev_num_r   <= prev_num_nxt;
    prev_den_r   <= prev_den_nxt;
    next_tick_r  <= next_tick_nxt;
    has_next_r   <= has_next_nxt;
    rem_r        <= rem_nxt;
    dvd_r        <= dvd_nxt;
    dsr_r        <= dsr_nxt;
    step_r       <= step_nxt;
    lower_r      <= lower_nxt;
    nat_r        <= nat_nxt;
    res_found_r  <= res_found_nxt;
    res_before_r <= res_before_nxt;
    res_after_r  <= res_after_nxt;
    res_avalid_r <= res_avalid_nxt;
    if (out_load) begin
      out_found_r  <= res_found_r;
      out_before_r <= res_before_r;
      out_after_r  <= res_after_r;
      out_avalid_r <= res_avalid_r;
    end
  end

endmodule
`default_nettype wire

/* sv/mbf_checker.sv */
// Port-level assertions for the measure boundary finder, bound to the top level.
`default_nettype none
module mbf_port_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic                       out_found,
  input wire logic [mbf_pkg::TICK_W-1:0] out_before,
  input wire logic [mbf_pkg::TICK_W-1:0] out_after,
  input wire logic                       out_avalid
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_before) && $stable(out_after) &&
    $stable(out_found) && $stable(out_avalid))
    else $error("result word changed while stalled");

  // Only one item is in work: an accepted word closes the input for the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in work");

  // Failed queries and writes return an all-zero word.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_before == '0 && out_after == '0 && !out_avalid)
    else $error("failed result carries nonzero fields");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_avalid |-> out_after == '0)
    else $error("absent upper boundary is not zero");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found && out_avalid |-> out_after >= out_before)
    else $error("upper boundary below lower boundary");

endmodule

bind measure_boundary_finder mbf_port_checker u_mbf_port_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_found  (out_ch.found),
  .out_before (out_ch.before_tick),
  .out_after  (out_ch.after_tick),
  .out_avalid (out_ch.after_valid)
);
`default_nettype wire
